### sv/ttr_pkg.sv
// Shared types and codes for the timer table with periodic reload.
// No dependencies.
`default_nettype none
package ttr_pkg;

  localparam logic [1:0] KIND_ADD    = 2'd0;
  localparam logic [1:0] KIND_CANCEL = 2'd1;
  localparam logic [1:0] KIND_TICK   = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  timer_id;
    logic [47:0] deadline;
    logic [47:0] period;
    logic [47:0] now_time;
  } cmd_t;

  typedef struct packed {
    logic [1:0] result_kind;
    logic       earliest_changed;
    logic       found;
    logic       expired_valid;
    logic [3:0] expired_id;
    logic       last;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD_SCAN,
    ST_TICK_SCAN,
    ST_SEL_SCAN,
    ST_EMIT
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;     // latch command, clear scan state
    logic scan_step;   // visit slot at scan index
    logic scan_clear;  // restart scan index and best tracker
    logic add_commit;  // write add, emit ack
    logic cancel_do;   // cancel, emit ack
    logic emit_best;   // pop best pending, emit report
    logic emit_none;   // emit empty tick report
  } ctl_t;

  // Datapath to controller
  typedef struct packed {
    logic scan_done;      // scan index at last slot
    logic any_pending;
    logic multi_pending;  // two or more expired timers still to report
  } sts_t;

endpackage
`default_nettype wire

### sv/ttr_ctrl.sv
// Controller state machine for the timer table.
// Depends on ttr_pkg.
`default_nettype none
module ttr_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  input  wire logic [1:0]      kind,
  input  wire ttr_pkg::sts_t   sts,
  output ttr_pkg::ctl_t        ctl,
  output logic                 busy
);

  ttr_pkg::state_t state, state_next;
  logic [1:0] op;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ttr_pkg::ST_IDLE;
      op <= ttr_pkg::KIND_ADD;
    end else begin
      state <= state_next;
      if (start && !busy) op <= kind;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ttr_pkg::ST_IDLE: begin
        if (start) begin
          if (kind == ttr_pkg::KIND_ADD) state_next = ttr_pkg::ST_ADD_SCAN;
          else if (kind == ttr_pkg::KIND_TICK) state_next = ttr_pkg::ST_TICK_SCAN;
          else state_next = ttr_pkg::ST_EMIT;
        end
      end
      ttr_pkg::ST_ADD_SCAN: if (sts.scan_done) state_next = ttr_pkg::ST_EMIT;
      ttr_pkg::ST_TICK_SCAN: if (sts.scan_done) state_next = ttr_pkg::ST_SEL_SCAN;
      ttr_pkg::ST_SEL_SCAN: if (sts.scan_done) state_next = ttr_pkg::ST_EMIT;
      ttr_pkg::ST_EMIT: begin
        // search again only while another expired timer remains after this one
        if (op == ttr_pkg::KIND_TICK && sts.multi_pending)
          state_next = ttr_pkg::ST_SEL_SCAN;
        else
          state_next = ttr_pkg::ST_IDLE;
      end
      default: state_next = ttr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctl = '0;
    busy = (state != ttr_pkg::ST_IDLE);
    case (state)
      ttr_pkg::ST_IDLE: ctl.capture = start;
      ttr_pkg::ST_ADD_SCAN: ctl.scan_step = 1'b1;
      ttr_pkg::ST_TICK_SCAN: begin
        ctl.scan_step = 1'b1;
        ctl.scan_clear = sts.scan_done;
      end
      ttr_pkg::ST_SEL_SCAN: ctl.scan_step = 1'b1;
      ttr_pkg::ST_EMIT: begin
        ctl.scan_clear = 1'b1;
        case (op)
          ttr_pkg::KIND_ADD: ctl.add_commit = 1'b1;
          ttr_pkg::KIND_CANCEL: ctl.cancel_do = 1'b1;
          ttr_pkg::KIND_TICK: begin
            ctl.emit_best = sts.any_pending;
            ctl.emit_none = !sts.any_pending;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

### sv/ttr_dp.sv
// Datapath: slot store, serial min/expiry scan, reload adder.
// Depends on ttr_pkg.
`default_nettype none
module ttr_dp #(
  parameter int SLOTS = 16,
  parameter int TIME_BITS = 48
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire ttr_pkg::cmd_t cmd_in,
  input  wire ttr_pkg::ctl_t ctl,
  output ttr_pkg::sts_t      sts,
  output logic               strobe,
  output ttr_pkg::rsp_t      rsp
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [TIME_BITS-1:0] TMAX = '1;

  logic [1:0]           c_kind;
  logic [3:0]           c_id;
  logic [TIME_BITS-1:0] c_dl, c_per, c_now;
  logic [SLOTS-1:0]     active, pending;
  logic [TIME_BITS-1:0] dl_mem [SLOTS];
  logic [TIME_BITS-1:0] per_mem [SLOTS];
  logic [IW-1:0]        idx, best;
  logic                 have, tick_seen;
  logic [TIME_BITS-1:0] best_dl;
  logic                 id_ok;
  logic [IW-1:0]        cid;
  logic [TIME_BITS-1:0] cur_dl, b_dl, b_per;
  logic [TIME_BITS:0]   sum;
  logic                 visit;
  logic                 mark_mode;
  logic                 best_hit;
  logic                 multi;
  logic                 rsp_load;
  ttr_pkg::rsp_t        rsp_next;

  assign id_ok = ({28'd0, c_id} < 32'(SLOTS));
  assign cid = IW'(c_id);
  assign cur_dl = dl_mem[idx];
  assign b_dl = dl_mem[best];
  assign b_per = per_mem[best];
  assign sum = {1'b0, b_dl} + {1'b0, b_per};
  assign multi = |(pending & (pending - 1'b1));
  assign sts.scan_done = (idx == IW'(SLOTS - 1));
  assign sts.any_pending = |pending;
  assign sts.multi_pending = multi;
  // scan visits active slots for add, active slots for tick, pending ones after
  assign visit = tick_seen ? pending[idx] : active[idx];
  assign mark_mode = (c_kind == ttr_pkg::KIND_TICK) && !tick_seen;
  assign best_hit = !mark_mode && visit && (!have || cur_dl < best_dl);
  assign rsp_load = ctl.add_commit || ctl.cancel_do || ctl.emit_best || ctl.emit_none;

  always_comb begin
    rsp_next = '0;
    rsp_next.last = 1'b1;
    if (ctl.add_commit) begin
      rsp_next.result_kind = ttr_pkg::KIND_ADD;
      rsp_next.earliest_changed = id_ok && (!have || c_dl < best_dl);
    end else if (ctl.cancel_do) begin
      rsp_next.result_kind = ttr_pkg::KIND_CANCEL;
      rsp_next.found = id_ok && active[cid];
    end else if (ctl.emit_best) begin
      rsp_next.result_kind = ttr_pkg::KIND_TICK;
      rsp_next.expired_valid = 1'b1;
      rsp_next.expired_id = 4'(best);
      rsp_next.last = !multi;
    end else if (ctl.emit_none) begin
      rsp_next.result_kind = ttr_pkg::KIND_TICK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= '0;
      pending <= '0;
      strobe <= 1'b0;
      idx <= '0;
      have <= 1'b0;
      tick_seen <= 1'b0;
    end else begin
      strobe <= rsp_load;
      if (rsp_load) rsp <= rsp_next;
      if (ctl.capture) begin
        c_kind <= cmd_in.kind;
        c_id <= cmd_in.timer_id;
        c_dl <= cmd_in.deadline[TIME_BITS-1:0];
        c_per <= cmd_in.period[TIME_BITS-1:0];
        c_now <= cmd_in.now_time[TIME_BITS-1:0];
      end
      if (ctl.capture || ctl.scan_clear) idx <= '0;
      else if (ctl.scan_step) idx <= idx + 1'b1;
      if (ctl.capture || ctl.scan_clear) have <= 1'b0;
      else if (ctl.scan_step && best_hit) have <= 1'b1;
      if (ctl.capture) tick_seen <= 1'b0;
      else if (ctl.scan_clear && c_kind == ttr_pkg::KIND_TICK) tick_seen <= 1'b1;
      if (ctl.scan_step) begin
        if (mark_mode) begin
          // mark expiry
          if (active[idx] && cur_dl < c_now) begin
            pending[idx] <= 1'b1;
            active[idx] <= 1'b0;
          end
        end else if (best_hit) begin
          best <= idx;
          best_dl <= cur_dl;
        end
      end
      if (ctl.add_commit && id_ok) begin
        active[cid] <= 1'b1;
        dl_mem[cid] <= c_dl;
        per_mem[cid] <= c_per;
      end
      if (ctl.cancel_do && id_ok) active[cid] <= 1'b0;
      if (ctl.emit_best) begin
        pending[best] <= 1'b0;
        if (b_per != '0) begin
          dl_mem[best] <= sum[TIME_BITS] ? TMAX : sum[TIME_BITS-1:0];
          active[best] <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

### sv/timer_table_with_periodic_reload_unit.sv
// Top level of the timer table with periodic reload.
// Depends on ttr_pkg, ttr_ctrl, ttr_dp.
//
//  channel   handshake        payload
//  command   start / busy     cmd  (ttr_pkg::cmd_t)
//  result    strobe           rsp  (ttr_pkg::rsp_t)
//
// Add: one serial min scan. Cancel: no scan.
// Tick: an expiry scan, then one search per expired timer
// (serial minimum search over the slot table), a single search when none expire.
// Reset clears all slot valid bits directly; no clearing pass.
// Results carry no back pressure: each strobe lasts one cycle.
`default_nettype none
module timer_table_with_periodic_reload_unit #(
  parameter int SLOTS = 16,
  parameter int TIME_BITS = 48
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire ttr_pkg::cmd_t cmd,
  output logic               busy,
  output logic               strobe,
  output ttr_pkg::rsp_t      rsp
);

  ttr_pkg::ctl_t ctl;
  ttr_pkg::sts_t sts;

  ttr_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .kind(cmd.kind),
    .sts(sts), .ctl(ctl), .busy(busy)
  );

  ttr_dp #(.SLOTS(SLOTS), .TIME_BITS(TIME_BITS)) u_dp (
    .clk(clk), .rst(rst), .cmd_in(cmd), .ctl(ctl), .sts(sts),
    .strobe(strobe), .rsp(rsp)
  );

endmodule
`default_nettype wire

### sv/ttr_checker.sv
// Port-level checks for the timer table; bound to the top level.
// Depends on ttr_pkg.
`default_nettype none
module ttr_checker (
  input wire logic          clk,
  input wire logic          rst,
  input wire logic          start,
  input wire ttr_pkg::cmd_t cmd,
  input wire logic          busy,
  input wire logic          strobe,
  input wire ttr_pkg::rsp_t rsp
);

  a_idle_no_strobe: assert property (@(posedge clk) disable iff (rst)
    !busy && !$past(busy) |-> !strobe) else $error("strobe while idle");

  a_strobe_last_drop: assert property (@(posedge clk) disable iff (rst)
    strobe && rsp.last |-> !busy) else $error("busy after last result");

  a_kind_flags: assert property (@(posedge clk) disable iff (rst)
    strobe && rsp.result_kind != ttr_pkg::KIND_TICK |-> !rsp.expired_valid && rsp.last)
    else $error("bad add/cancel result");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("accept not busy");

endmodule

bind timer_table_with_periodic_reload_unit ttr_checker u_chk (.*);
`default_nettype wire

### tb/timer_table_with_periodic_reload_unit_tb.sv
// Testbench for the timer table with periodic reload: directed table, then random traffic,
// every result checked against a behavioral timer table kept here.
// Depends on ttr_pkg and timer_table_with_periodic_reload_unit.
`timescale 1ns / 100ps
module timer_table_with_periodic_reload_unit_tb;

  localparam int NSLOT = 16;
  localparam logic [47:0] TMAX = 48'hFFFF_FFFF_FFFF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int EXP_DEPTH = 64;
  localparam int ROW_MAX = 48;
  localparam logic [1:0] KIND_BAD = 2'd3;

  typedef struct {
    ttr_pkg::cmd_t c;
    logic chk;  // typed expectation present
    ttr_pkg::rsp_t r;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  ttr_pkg::cmd_t cmd = '0;
  logic busy, strobe;
  ttr_pkg::rsp_t rsp;

  timer_table_with_periodic_reload_unit DUT (
    .clk(clk), .rst(rst), .start(start), .cmd(cmd),
    .busy(busy), .strobe(strobe), .rsp(rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // model of the table
  logic        tm_active [NSLOT];
  logic [47:0] tm_deadline [NSLOT];
  logic [47:0] tm_period [NSLOT];
  // expected results, oldest at exp_rd
  ttr_pkg::rsp_t exp_fifo [EXP_DEPTH];
  int exp_wr = 0;
  int exp_rd = 0;
  stim_row_t rows [ROW_MAX];
  int nrows = 0;
  int errors = 0;
  int cycles = 0;

  function automatic ttr_pkg::rsp_t mk_rsp(logic [1:0] k, logic ec, logic fd, logic ev,
                                           logic [3:0] eid, logic lst);
    ttr_pkg::rsp_t r;
    r.result_kind = k; r.earliest_changed = ec; r.found = fd;
    r.expired_valid = ev; r.expired_id = eid; r.last = lst;
    return r;
  endfunction

  function automatic void exp_put(input ttr_pkg::rsp_t r);
    exp_fifo[exp_wr % EXP_DEPTH] = r;
    exp_wr++;
  endfunction

  function automatic void add_row(input ttr_pkg::cmd_t c, input logic chk,
                                  input ttr_pkg::rsp_t r);
    rows[nrows] = '{c, chk, r};
    nrows++;
  endfunction

  task automatic predict_timers(input ttr_pkg::cmd_t c);
    logic any;
    logic [47:0] mn;
    logic exp_set [NSLOT];
    int remaining, best;
    if (c.kind == ttr_pkg::KIND_ADD) begin
      any = 1'b0; mn = '0;
      for (int i = 0; i < NSLOT; i++)
        if (tm_active[i] && (!any || tm_deadline[i] < mn)) begin
          mn = tm_deadline[i]; any = 1'b1;
        end
      tm_active[c.timer_id] = 1'b1;
      tm_deadline[c.timer_id] = c.deadline;
      tm_period[c.timer_id] = c.period;
      exp_put(mk_rsp(ttr_pkg::KIND_ADD, !any || c.deadline < mn, 0, 0, 0, 1));
    end else if (c.kind == ttr_pkg::KIND_CANCEL) begin
      exp_put(mk_rsp(ttr_pkg::KIND_CANCEL, 0, tm_active[c.timer_id], 0, 0, 1));
      tm_active[c.timer_id] = 1'b0;
    end else if (c.kind == ttr_pkg::KIND_TICK) begin
      remaining = 0;
      for (int i = 0; i < NSLOT; i++) begin
        exp_set[i] = tm_active[i] && tm_deadline[i] < c.now_time;
        if (exp_set[i]) begin
          tm_active[i] = 1'b0; remaining++;
        end
      end
      if (remaining == 0) exp_put(mk_rsp(ttr_pkg::KIND_TICK, 0, 0, 0, 0, 1));
      while (remaining > 0) begin
        best = -1;
        for (int i = 0; i < NSLOT; i++)
          if (exp_set[i] && (best < 0 || tm_deadline[i] < tm_deadline[best])) best = i;
        exp_set[best] = 1'b0;
        remaining--;
        exp_put(mk_rsp(ttr_pkg::KIND_TICK, 0, 0, 1, best[3:0], remaining == 0));
        if (tm_period[best] != 0) begin
          tm_deadline[best] = (tm_deadline[best] > TMAX - tm_period[best]) ? TMAX
                              : tm_deadline[best] + tm_period[best];
          tm_active[best] = 1'b1;
        end
      end
    end
  endtask

  // result checker
  always @(posedge clk) begin
    ttr_pkg::rsp_t e;
    cycles <= cycles + 1;
    if (!rst && strobe) begin
      if (exp_wr == exp_rd) begin
        $error("unexpected result %h", rsp);
        errors++;
      end else begin
        e = exp_fifo[exp_rd % EXP_DEPTH];
        exp_rd++;
        if (rsp.result_kind !== e.result_kind) begin
          $error("result_kind exp %0d got %0d", e.result_kind, rsp.result_kind); errors++;
        end
        if (rsp.earliest_changed !== e.earliest_changed) begin
          $error("earliest_changed exp %0d got %0d", e.earliest_changed,
                 rsp.earliest_changed); errors++;
        end
        if (rsp.found !== e.found) begin
          $error("found exp %0d got %0d", e.found, rsp.found); errors++;
        end
        if (rsp.expired_valid !== e.expired_valid) begin
          $error("expired_valid exp %0d got %0d", e.expired_valid, rsp.expired_valid);
          errors++;
        end
        if (rsp.expired_id !== e.expired_id) begin
          $error("expired_id exp %0d got %0d", e.expired_id, rsp.expired_id); errors++;
        end
        if (rsp.last !== e.last) begin
          $error("last exp %0d got %0d", e.last, rsp.last); errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic logic [47:0] rand_time();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return TMAX - 48'($urandom_range(0, 3));
      2: return 48'({$urandom, $urandom});
      default: return 48'(1000 + $urandom_range(0, 4000));
    endcase
  endfunction

  function automatic ttr_pkg::cmd_t rand_cmd();
    return ttr_pkg::cmd_t'(150'({$urandom, $urandom, $urandom, $urandom, $urandom}));
  endfunction

  // send one transaction; inputs change on the falling edge
  task automatic send_cmd(input ttr_pkg::cmd_t c);
    int gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) gap = 0;
    repeat (gap) @(negedge clk);
    while (busy) @(negedge clk);
    cmd = c;
    start = 1'b1;
    @(posedge clk);
    predict_timers(c);
    @(negedge clk);
    start = 1'b0;
    cmd = rand_cmd();
  endtask

  function automatic ttr_pkg::cmd_t mk_cmd(logic [1:0] k, logic [3:0] id, logic [47:0] dl,
                                           logic [47:0] per, logic [47:0] nw);
    ttr_pkg::cmd_t c;
    c.kind = k; c.timer_id = id; c.deadline = dl; c.period = per; c.now_time = nw;
    return c;
  endfunction

  initial begin
    ttr_pkg::cmd_t c;
    int r;
    for (int i = 0; i < NSLOT; i++) begin
      tm_active[i] = 0; tm_deadline[i] = '0; tm_period[i] = '0;
    end
    // directed table
    add_row(mk_cmd(ttr_pkg::KIND_TICK, 0, 0, 0, TMAX), 1,
            mk_rsp(ttr_pkg::KIND_TICK, 0, 0, 0, 0, 1));
    add_row(mk_cmd(ttr_pkg::KIND_CANCEL, 15, 0, 0, 0), 1,
            mk_rsp(ttr_pkg::KIND_CANCEL, 0, 0, 0, 0, 1));
    add_row(mk_cmd(ttr_pkg::KIND_ADD, 15, TMAX, 0, 0), 1,
            mk_rsp(ttr_pkg::KIND_ADD, 1, 0, 0, 0, 1));
    add_row(mk_cmd(ttr_pkg::KIND_ADD, 15, 100, 0, 0), 0, '0);   // replace own id
    add_row(mk_cmd(ttr_pkg::KIND_ADD, 0, 0, TMAX, 0), 0, '0);
    add_row(mk_cmd(ttr_pkg::KIND_ADD, 3, 100, 50, 0), 0, '0);   // tie with 15
    add_row(mk_cmd(ttr_pkg::KIND_ADD, 7, TMAX - 5, 10, 0), 0, '0);
    add_row(mk_cmd(KIND_BAD, 5, 1, 1, TMAX), 0, '0);            // ignored
    add_row(mk_cmd(ttr_pkg::KIND_TICK, 0, 0, 0, 0), 0, '0);
    add_row(mk_cmd(ttr_pkg::KIND_TICK, 0, 0, 0, 101), 0, '0);
    add_row(mk_cmd(ttr_pkg::KIND_TICK, 0, 0, 0, TMAX), 0, '0);  // saturating reloads
    add_row(mk_cmd(ttr_pkg::KIND_TICK, 0, 0, 0, TMAX), 0, '0);
    add_row(mk_cmd(ttr_pkg::KIND_CANCEL, 0, 0, 0, 0), 0, '0);
    add_row(mk_cmd(ttr_pkg::KIND_CANCEL, 0, 0, 0, 0), 1,
            mk_rsp(ttr_pkg::KIND_CANCEL, 0, 0, 0, 0, 1));
    add_row(mk_cmd(ttr_pkg::KIND_CANCEL, 3, TMAX, TMAX, TMAX), 0, '0);
    add_row(mk_cmd(ttr_pkg::KIND_CANCEL, 7, 0, 0, 0), 0, '0);
    for (int i = 0; i < NSLOT; i++)
      add_row(mk_cmd(ttr_pkg::KIND_ADD, i[3:0], 48'(5), 48'(i), 0), 0, '0);
    add_row(mk_cmd(ttr_pkg::KIND_TICK, 0, 0, 0, 6), 0, '0);     // all sixteen expire

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int k = 0; k < nrows; k++) begin
      // drain so the new row's prediction is the only one outstanding
      while (exp_wr != exp_rd) @(negedge clk);
      send_cmd(rows[k].c);
      if (rows[k].chk && (exp_wr != exp_rd + 1 ||
                          exp_fifo[(exp_wr - 1) % EXP_DEPTH] != rows[k].r)) begin
        $error("directed row %0d: table value disagrees with prediction", k);
        errors++;
      end
    end

    // random traffic, mostly meaningful adds/ticks at random times
    for (int n = 0; n < 128; n++) begin
      c = rand_cmd();
      r = $urandom_range(0, 99);
      if (r < 45) begin
        c.kind = ttr_pkg::KIND_ADD; c.deadline = rand_time();
        c.period = ($urandom_range(0, 2) == 0) ? '0 : rand_time();
      end else if (r < 62) c.kind = ttr_pkg::KIND_CANCEL;
      else if (r < 96) begin
        c.kind = ttr_pkg::KIND_TICK; c.now_time = rand_time();
      end else c.kind = KIND_BAD;
      send_cmd(c);
    end

    while (exp_wr != exp_rd) @(posedge clk);
    repeat (NSLOT * 20) @(posedge clk);
    if (errors == 0 && exp_wr == exp_rd) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end
endmodule
